// File: rtl/core/cdv_pkg.sv
// cdv_pkg: types, codes and helpers for the cell descriptor validator
// used by cell_descriptor_validator; no dependencies

package cdv_pkg;

    typedef struct packed {
        logic [7:0] cell_byte;
        logic [7:0] this_cell_index;
        logic       end_of_buffer;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  cell_size;
        logic [2:0]  ref_count;
        logic [10:0] bit_length;
        logic        is_pruned;
    } t_out_word;

    typedef enum logic [2:0] {
        PH_D1,
        PH_D2,
        PH_DATA,
        PH_REFS,
        PH_DROP
    } t_phase;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_DESC  = 2'd1;
    localparam logic [1:0] ST_BAD_REF   = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_TOTAL       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REFS          = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRUNED_DESCRIPTOR = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRUNED_DATA_BYTES = 2'd3;

    localparam logic [7:0] RST_CELLS_TOTAL       = 8'd0;
    localparam logic [2:0] RST_MAX_REFS          = 3'd4;
    localparam logic [7:0] RST_PRUNED_DESCRIPTOR = 8'd40;
    localparam logic [7:0] RST_PRUNED_DATA_BYTES = 8'd36;

    // trailing zero bits of a byte, saturating at 7
    function automatic logic [2:0] trailing_zeros(input logic [7:0] b);
        logic [2:0] tz;
        tz = 3'd7;
        for (int i = 6; i >= 0; i--) begin
            if (b[i]) begin
                tz = 3'(i);
            end
        end
        return tz;
    endfunction

    // data size in bytes: half of d2, rounded up
    function automatic logic [7:0] data_bytes(input logic [7:0] d2);
        return {1'b0, d2[7:1]} + {7'b0, d2[0]};
    endfunction

endpackage

// File: rtl/core/cell_descriptor_validator.sv
// cell_descriptor_validator: checks serialized cells one byte per word
// depends on cdv_pkg
//
// Usage
//   input channel (i_in_valid / o_in_ready / i_in_word): one byte of the cell
//   buffer per word, with the index of the cell and an end-of-buffer flag
//   output channel (o_out_valid / i_out_ready / o_out_word): one result word
//   per cell (status, size, reference count, bit length, pruned flag)
//   config port (i_cfg_we / i_cfg_idx / i_cfg_data): write only while idle
// Timing
//   one byte per cycle sustained while results are taken; a byte is
//   registered at acceptance and processed when the parser advances; a cell's
//   result is registered for output; the per-byte state update is the only loop
// Reset
//   synchronous, active low; parser waits for a descriptor byte, registers
//   return to their defaults, both pipeline stages empty
// Stall
//   a waiting result is held in the output register; the input register still
//   takes a byte and input acceptance stops only while both are full

module cell_descriptor_validator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  cdv_pkg::t_in_word                   i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output cdv_pkg::t_out_word                  o_out_word,
    input  logic                                i_cfg_we,
    input  logic [cdv_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [cdv_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic [7:0] r_cells_total;
    logic [2:0] r_max_refs;
    logic [7:0] r_pruned_desc;
    logic [7:0] r_pruned_bytes;

    logic              r_in_valid;
    cdv_pkg::t_in_word r_in_word;
    logic               r_out_valid;
    cdv_pkg::t_out_word r_out_word;

    cdv_pkg::t_phase r_phase, n_phase;
    logic [7:0] r_desc_one, n_desc_one;
    logic [7:0] r_desc_two, n_desc_two;
    logic [7:0] r_pos, n_pos;
    logic [7:0] r_lnz_pos, n_lnz_pos;
    logic [2:0] r_lnz_tz, n_lnz_tz;
    logic       r_seen, n_seen;

    logic       advance;
    logic       emit;
    logic [1:0] status;
    logic [7:0] b;
    logic       eob;
    logic [7:0] ds_b;
    logic [7:0] ds_r;
    logic [7:0] ds_n;
    logic [7:0] pos_inc;
    logic [2:0] refs_r;
    logic       pruned_b;
    cdv_pkg::t_out_word res;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells_total  <= cdv_pkg::RST_CELLS_TOTAL;
            r_max_refs     <= cdv_pkg::RST_MAX_REFS;
            r_pruned_desc  <= cdv_pkg::RST_PRUNED_DESCRIPTOR;
            r_pruned_bytes <= cdv_pkg::RST_PRUNED_DATA_BYTES;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cdv_pkg::CFG_CELLS_TOTAL:       r_cells_total  <= i_cfg_data;
                cdv_pkg::CFG_MAX_REFS:          r_max_refs     <= i_cfg_data[2:0];
                cdv_pkg::CFG_PRUNED_DESCRIPTOR: r_pruned_desc  <= i_cfg_data;
                cdv_pkg::CFG_PRUNED_DATA_BYTES: r_pruned_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_word <= i_in_word;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= cdv_pkg::PH_D1;
            r_desc_one <= 8'd0;
            r_desc_two <= 8'd0;
            r_pos      <= 8'd0;
            r_lnz_pos  <= 8'd0;
            r_lnz_tz   <= 3'd0;
            r_seen     <= 1'b0;
        end else if (advance) begin
            r_phase    <= n_phase;
            r_desc_one <= n_desc_one;
            r_desc_two <= n_desc_two;
            r_pos      <= n_pos;
            r_lnz_pos  <= n_lnz_pos;
            r_lnz_tz   <= n_lnz_tz;
            r_seen     <= n_seen;
        end
    end

    always_comb begin
        b        = r_in_word.cell_byte;
        eob      = r_in_word.end_of_buffer;
        ds_b     = cdv_pkg::data_bytes(b);
        ds_r     = cdv_pkg::data_bytes(r_desc_two);
        refs_r   = r_desc_one[2:0];
        pruned_b = (b == r_pruned_desc);
        pos_inc  = r_pos + 8'd1;

        n_phase    = r_phase;
        n_desc_one = r_desc_one;
        n_desc_two = r_desc_two;
        n_pos      = r_pos;
        n_lnz_pos  = r_lnz_pos;
        n_lnz_tz   = r_lnz_tz;
        n_seen     = r_seen;
        emit       = 1'b0;
        status     = cdv_pkg::ST_OK;

        case (r_phase)
            cdv_pkg::PH_D1: begin
                n_desc_one = b;
                n_desc_two = 8'd0;
                n_pos      = 8'd0;
                n_lnz_pos  = 8'd0;
                n_lnz_tz   = 3'd0;
                n_seen     = 1'b0;
                if (b[4] || (b[3] && !pruned_b) || (b[2:0] > r_max_refs)) begin
                    emit   = 1'b1;
                    status = cdv_pkg::ST_BAD_DESC;
                end else begin
                    n_phase = cdv_pkg::PH_D2;
                    if (eob) begin
                        emit   = 1'b1;
                        status = cdv_pkg::ST_TRUNCATED;
                    end
                end
            end
            cdv_pkg::PH_D2: begin
                n_desc_two = b;
                if ((r_desc_one == r_pruned_desc) && (ds_b != r_pruned_bytes)) begin
                    emit   = 1'b1;
                    status = cdv_pkg::ST_BAD_DESC;
                end else begin
                    n_pos = 8'd0;
                    if (ds_b != 8'd0) begin
                        n_phase = cdv_pkg::PH_DATA;
                    end else if (refs_r != 3'd0) begin
                        n_phase = cdv_pkg::PH_REFS;
                    end else begin
                        emit = 1'b1;
                    end
                    if (!emit && eob) begin
                        emit   = 1'b1;
                        status = cdv_pkg::ST_TRUNCATED;
                    end
                end
            end
            cdv_pkg::PH_DATA: begin
                if (b != 8'd0) begin
                    n_lnz_pos = r_pos;
                    n_lnz_tz  = cdv_pkg::trailing_zeros(b);
                    n_seen    = 1'b1;
                end
                n_pos = pos_inc;
                if (pos_inc >= ds_r) begin
                    if (refs_r == 3'd0) begin
                        emit = 1'b1;
                    end else begin
                        n_phase = cdv_pkg::PH_REFS;
                        n_pos   = 8'd0;
                    end
                end
                if (!emit && eob) begin
                    emit   = 1'b1;
                    status = cdv_pkg::ST_TRUNCATED;
                end
            end
            cdv_pkg::PH_REFS: begin
                if (!((b <= r_cells_total) && (b > r_in_word.this_cell_index))) begin
                    emit   = 1'b1;
                    status = cdv_pkg::ST_BAD_REF;
                end else begin
                    n_pos = pos_inc;
                    if (pos_inc >= {5'd0, refs_r}) begin
                        emit = 1'b1;
                    end else if (eob) begin
                        emit   = 1'b1;
                        status = cdv_pkg::ST_TRUNCATED;
                    end
                end
            end
            cdv_pkg::PH_DROP: begin
                if (eob) begin
                    n_phase = cdv_pkg::PH_D1;
                end
            end
            default: begin
                n_phase = cdv_pkg::PH_D1;
            end
        endcase

        if (emit) begin
            n_phase = ((status == cdv_pkg::ST_OK) || eob) ? cdv_pkg::PH_D1 : cdv_pkg::PH_DROP;
        end

        // result fields from the updated state
        ds_n          = cdv_pkg::data_bytes(n_desc_two);
        res.status    = status;
        res.ref_count = n_desc_one[2:0];
        res.is_pruned = (n_desc_one == r_pruned_desc);
        if (status == cdv_pkg::ST_OK) begin
            res.cell_size = 8'd2 + ds_n + {5'd0, n_desc_one[2:0]};
            if (!n_desc_two[0]) begin
                res.bit_length = {ds_n, 3'd0};
            end else if (!n_seen) begin
                res.bit_length = 11'd0;
            end else begin
                res.bit_length = ({n_lnz_pos, 3'd0} + 11'd8) - ({8'd0, n_lnz_tz} + 11'd1);
            end
        end else begin
            res.cell_size  = 8'd0;
            res.bit_length = 11'd0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_word <= res;
        end
    end

    // checks
    a_drop_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_phase == cdv_pkg::PH_DROP) |-> !emit)
        else $error("result produced while dropping bytes");

    a_err_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.status != cdv_pkg::ST_OK) |->
        (r_out_word.cell_size == 8'd0 && r_out_word.bit_length == 11'd0))
        else $error("error result carries size or bit length");

    a_ok_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && emit && status == cdv_pkg::ST_OK) |=>
        (o_out_valid && o_out_word.cell_size >= 8'd2 && o_out_word.bit_length <= 11'd1024))
        else $error("good cell result out of range");

    a_error_leaves_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && emit && status != cdv_pkg::ST_OK && !eob) |=>
        (r_phase == cdv_pkg::PH_DROP))
        else $error("error inside buffer did not start dropping");

endmodule
